// File: design/offaxis_hologram_render_defines.svh
// Assertion macros for the off-axis hologram renderer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef OFFAXIS_HOLOGRAM_RENDER_DEFINES_SVH
`define OFFAXIS_HOLOGRAM_RENDER_DEFINES_SVH

// same-cycle implication
`define OHR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("offaxis_hologram_render: same-cycle check failed");

// next-cycle implication
`define OHR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("offaxis_hologram_render: next-cycle check failed");

`endif

// File: design/ohr_pkg.sv
// Shared types and constants for the off-axis hologram renderer.
// Used by ohr_ctrl, ohr_datapath and offaxis_hologram_render.
`default_nettype none
package ohr_pkg;

  localparam int OHR_STEP_W = 5;
  localparam int OHR_SQRT_STEPS = 25;
  localparam int OHR_DIV_STEPS = 8;

  localparam logic [2:0] OHR_REG_MODE = 3'd0;
  localparam logic [2:0] OHR_REG_WIDTH = 3'd1;
  localparam logic [2:0] OHR_REG_HEIGHT = 3'd2;
  localparam logic [2:0] OHR_REG_TILT_X = 3'd3;
  localparam logic [2:0] OHR_REG_TILT_Y = 3'd4;

  localparam logic [1:0] OHR_MODE_INTENSITY = 2'd0;
  localparam logic [1:0] OHR_MODE_AMPLITUDE = 2'd1;

  localparam logic signed [25:0] OHR_CORDIC_X0 = 26'sd2547003;
  localparam logic signed [33:0] OHR_HALF_TURN = 34'sd2147483648;

  // atan(2^-i) in 1/2^32 turn
  localparam logic [31:0] OHR_ATAN [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic                  capture;
    logic                  rot_step;
    logic                  rot_round;
    logic                  sq_re;
    logic                  sq_im;
    logic                  sq_sum;
    logic                  sqrt_step;
    logic                  vec_init;
    logic                  vec_step;
    logic                  vec_done;
    logic                  commit;
    logic                  rd_issue;
    logic                  div_init;
    logic                  div_step;
    logic                  emit;
    logic [OHR_STEP_W-1:0] step;
  } ohr_cmd_t;

  typedef struct packed {
    logic       op;
    logic       frame_ready;
    logic [1:0] mode;
  } ohr_sts_t;

endpackage
`default_nettype wire

// File: design/ohr_ctrl.sv
// Sequencer for the hologram renderer: one item at a time.
// Depends on ohr_pkg; drives ohr_datapath through ohr_cmd_t.
`default_nettype none
module ohr_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire ohr_pkg::ohr_sts_t sts,
  output ohr_pkg::ohr_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ROT, S_ROUND, S_SQRE, S_SQIM, S_SUM, S_SQRT,
    S_VECI, S_VEC, S_VECD, S_COMMIT, S_RD, S_DIVI, S_DIV, S_FIN, S_OUT
  } state_t;

  localparam logic [ohr_pkg::OHR_STEP_W-1:0] ROT_LAST =
    ohr_pkg::OHR_STEP_W'(CORDIC_STEPS - 1);
  localparam logic [ohr_pkg::OHR_STEP_W-1:0] SQRT_LAST =
    ohr_pkg::OHR_STEP_W'(ohr_pkg::OHR_SQRT_STEPS - 1);
  localparam logic [ohr_pkg::OHR_STEP_W-1:0] DIV_LAST =
    ohr_pkg::OHR_STEP_W'(ohr_pkg::OHR_DIV_STEPS - 1);

  state_t                        state_r;
  logic [ohr_pkg::OHR_STEP_W-1:0] step_r;
  logic                          out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_DISP;
        S_DISP: begin
          step_r <= '0;
          if (sts.op) state_r <= sts.frame_ready ? S_RD : S_IDLE;
          else state_r <= S_ROT;
        end
        S_ROT: begin
          if (step_r == ROT_LAST) begin
            step_r  <= '0;
            state_r <= S_ROUND;
          end else step_r <= step_r + 1'b1;
        end
        S_ROUND: state_r <= S_SQRE;
        S_SQRE:  state_r <= S_SQIM;
        S_SQIM:  state_r <= S_SUM;
        S_SUM: begin
          step_r <= '0;
          if (sts.mode == ohr_pkg::OHR_MODE_INTENSITY) state_r <= S_COMMIT;
          else if (sts.mode == ohr_pkg::OHR_MODE_AMPLITUDE) state_r <= S_SQRT;
          else state_r <= S_VECI;
        end
        S_SQRT: begin
          if (step_r == SQRT_LAST) state_r <= S_COMMIT;
          else step_r <= step_r + 1'b1;
        end
        S_VECI: begin
          step_r  <= '0;
          state_r <= S_VEC;
        end
        S_VEC: begin
          if (step_r == ROT_LAST) state_r <= S_VECD;
          else step_r <= step_r + 1'b1;
        end
        S_VECD:   state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_IDLE;
        S_RD:     state_r <= S_DIVI;
        S_DIVI: begin
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (step_r == DIV_LAST) state_r <= S_FIN;
          else step_r <= step_r + 1'b1;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.step      = step_r;
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.rot_step  = (state_r == S_ROT);
    cmd.rot_round = (state_r == S_ROUND);
    cmd.sq_re     = (state_r == S_SQRE);
    cmd.sq_im     = (state_r == S_SQIM);
    cmd.sq_sum    = (state_r == S_SUM);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.vec_init  = (state_r == S_VECI);
    cmd.vec_step  = (state_r == S_VEC);
    cmd.vec_done  = (state_r == S_VECD);
    cmd.commit    = (state_r == S_COMMIT);
    cmd.rd_issue  = (state_r == S_RD);
    cmd.div_init  = (state_r == S_DIVI);
    cmd.div_step  = (state_r == S_DIV);
    cmd.emit      = (state_r == S_FIN);
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: design/ohr_datapath.sv
// Datapath: config registers, CORDIC, squarer, root, divider, frame store.
// Depends on ohr_pkg; sequenced by ohr_ctrl.
`default_nettype none
module ohr_datapath #(
  parameter int MAX_SIDE = 512
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ohr_pkg::ohr_cmd_t   cmd,
  output ohr_pkg::ohr_sts_t        sts,
  input  wire logic                in_op,
  input  wire logic signed [23:0]  in_spec_real,
  input  wire logic signed [23:0]  in_spec_imag,
  input  wire logic                cfg_wr,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output logic [7:0]               out_pixel,
  output logic                     out_frame_end
);

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration
  logic [1:0]  mode_r;
  logic [9:0]  fw_r, fh_r;
  logic [15:0] tx_r, ty_r;

  // frame control
  logic [CNT_W-1:0]  col_r, row_r;
  logic [15:0]       row_ph_r, pix_ph_r;
  logic [ADDR_W-1:0] rd_idx_r;
  logic              frame_ready_r;
  logic [47:0]       peak_r;

  // payload
  logic                     op_r;
  logic signed [23:0]       sre_r, sim_r;
  logic signed [25:0]       rx_r, ry_r;
  logic signed [33:0]       rz_r;
  logic signed [26:0]       re_r, im_r;
  logic [ADDR_W-1:0]        addr_r;
  logic [53:0]              sqa_r, sqb_r;
  logic [47:0]              val_r;
  logic [48:0]              sv_r;
  logic [49:0]              sr_r, sbit_r;
  logic signed [29:0]       vx_r, vy_r;
  logic signed [33:0]       vz_r;
  logic [16:0]              ph_r;
  logic [47:0]              rd_data_r;
  logic [55:0]              rem_r;
  logic [7:0]               pix_r;
  logic                     dfix_r;
  logic [7:0]               out_pixel_r;
  logic                     out_frame_end_r;
  logic [47:0]              mem [DEPTH];

  logic [SIDE_W-1:0] w_eff, h_eff;

  always_comb begin
    if (fw_r == '0) w_eff = SIDE_W'(1);
    else if (32'(fw_r) > MAX_SIDE) w_eff = SIDE_W'(MAX_SIDE);
    else w_eff = SIDE_W'(fw_r);
    if (fh_r == '0) h_eff = SIDE_W'(1);
    else if (32'(fh_r) > MAX_SIDE) h_eff = SIDE_W'(MAX_SIDE);
    else h_eff = SIDE_W'(fh_r);
  end

  // rotation CORDIC terms
  logic                     flip;
  logic [31:0]              z0;
  logic signed [33:0]       atan_s;
  logic signed [26:0]       xr, yr;
  logic signed [18:0]       xs, ys;
  logic signed [15:0]       cos_q, sin_q;
  logic signed [26:0]       mul_a;
  logic signed [53:0]       prod;
  logic [54:0]              sq_sum;
  logic [50:0]              sq_sh;
  logic [47:0]              sq_sat;
  logic [49:0]              sq_t;
  logic signed [34:0]       vfin;
  logic [47:0]              res;
  logic [55:0]              num;
  logic [55:0]              dsub;
  logic [2:0]               dk;
  logic                     col_wrap, row_wrap, rd_last;

  always_comb begin
    flip   = pix_ph_r[15] ^ pix_ph_r[14];
    z0     = {pix_ph_r[15] ^ flip, pix_ph_r[14:0], 16'b0};
    atan_s = $signed({2'b00, ohr_pkg::OHR_ATAN[cmd.step]});
    xr     = {rx_r[25], rx_r} + 27'sd128;
    yr     = {ry_r[25], ry_r} + 27'sd128;
    xs     = xr[26:8];
    ys     = yr[26:8];
    if (xs > 19'sd16384) cos_q = 16'sd16384;
    else if (xs < -19'sd16384) cos_q = -16'sd16384;
    else cos_q = xs[15:0];
    if (ys > 19'sd16384) sin_q = 16'sd16384;
    else if (ys < -19'sd16384) sin_q = -16'sd16384;
    else sin_q = ys[15:0];
    mul_a  = cmd.sq_re ? re_r : im_r;
    prod   = mul_a * mul_a;
    sq_sum = {1'b0, sqa_r} + {1'b0, sqb_r};
    sq_sh  = sq_sum[54:4];
    sq_sat = (|sq_sh[50:48]) ? 48'hFFFF_FFFF_FFFF : sq_sh[47:0];
    sq_t   = sr_r + sbit_r;
    vfin   = {vz_r[33], vz_r} + 35'sd2147483648;
    if (mode_r == ohr_pkg::OHR_MODE_INTENSITY) res = val_r;
    else if (mode_r == ohr_pkg::OHR_MODE_AMPLITUDE) res = sr_r[47:0];
    else res = {31'b0, ph_r};
    num     = {rd_data_r, 8'b0} - {8'b0, rd_data_r};
    dk      = 3'd7 - cmd.step[2:0];
    dsub    = {8'b0, peak_r} << dk;
    col_wrap = (32'(col_r) + 32'd1 >= 32'(w_eff));
    row_wrap = (32'(row_r) + 32'd1 >= 32'(h_eff));
    rd_last  = (32'(rd_idx_r) + 32'd1 >= 32'(w_eff) * 32'(h_eff));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= '0;
      fw_r          <= 10'd512;
      fh_r          <= 10'd512;
      tx_r          <= '0;
      ty_r          <= '0;
      col_r         <= '0;
      row_r         <= '0;
      row_ph_r      <= '0;
      pix_ph_r      <= '0;
      rd_idx_r      <= '0;
      frame_ready_r <= 1'b0;
      peak_r        <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          ohr_pkg::OHR_REG_MODE:   mode_r <= cfg_data[1:0];
          ohr_pkg::OHR_REG_WIDTH:  fw_r   <= cfg_data[9:0];
          ohr_pkg::OHR_REG_HEIGHT: fh_r   <= cfg_data[9:0];
          ohr_pkg::OHR_REG_TILT_X: tx_r   <= cfg_data;
          ohr_pkg::OHR_REG_TILT_Y: ty_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (col_r == '0 && row_r == '0) peak_r <= res;
        else if (res > peak_r) peak_r <= res;
        if (col_wrap) begin
          col_r <= '0;
          if (row_wrap) begin
            row_r         <= '0;
            row_ph_r      <= '0;
            pix_ph_r      <= '0;
            frame_ready_r <= 1'b1;
            rd_idx_r      <= '0;
          end else begin
            row_r    <= row_r + 1'b1;
            row_ph_r <= row_ph_r + ty_r;
            pix_ph_r <= row_ph_r + ty_r;
          end
        end else begin
          col_r    <= col_r + 1'b1;
          pix_ph_r <= pix_ph_r + tx_r;
        end
      end
      if (cmd.emit) begin
        if (rd_last) begin
          frame_ready_r <= 1'b0;
          rd_idx_r      <= '0;
        end else rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      sre_r <= in_spec_real;
      sim_r <= in_spec_imag;
      rx_r  <= flip ? -ohr_pkg::OHR_CORDIC_X0 : ohr_pkg::OHR_CORDIC_X0;
      ry_r  <= '0;
      rz_r  <= {{2{z0[31]}}, z0};
    end
    if (cmd.rot_step) begin
      if (!rz_r[33]) begin
        rx_r <= rx_r - (ry_r >>> cmd.step);
        ry_r <= ry_r + (rx_r >>> cmd.step);
        rz_r <= rz_r - atan_s;
      end else begin
        rx_r <= rx_r + (ry_r >>> cmd.step);
        ry_r <= ry_r - (rx_r >>> cmd.step);
        rz_r <= rz_r + atan_s;
      end
    end
    if (cmd.rot_round) begin
      re_r   <= {sre_r[23], sre_r, 2'b00} + {{11{cos_q[15]}}, cos_q};
      im_r   <= {sim_r[23], sim_r, 2'b00} + {{11{sin_q[15]}}, sin_q};
      addr_r <= ADDR_W'(32'(row_r) * 32'(w_eff) + 32'(col_r));
    end
    if (cmd.sq_re) sqa_r <= prod[53:0];
    if (cmd.sq_im) sqb_r <= prod[53:0];
    if (cmd.sq_sum) begin
      val_r  <= sq_sat;
      sv_r   <= {1'b0, sq_sat};
      sr_r   <= '0;
      sbit_r <= 50'd1 << 48;
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, sv_r} >= sq_t) begin
        sv_r <= sv_r - sq_t[48:0];
        sr_r <= (sr_r >> 1) + sbit_r;
      end else sr_r <= sr_r >> 1;
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.vec_init) begin
      if (re_r[26]) begin
        vx_r <= -{{3{re_r[26]}}, re_r};
        vy_r <= -{{3{im_r[26]}}, im_r};
        vz_r <= (im_r > 27'sd0) ? ohr_pkg::OHR_HALF_TURN : -ohr_pkg::OHR_HALF_TURN;
      end else begin
        vx_r <= {{3{re_r[26]}}, re_r};
        vy_r <= {{3{im_r[26]}}, im_r};
        vz_r <= '0;
      end
    end
    if (cmd.vec_step) begin
      if (vy_r > 30'sd0) begin
        vx_r <= vx_r + (vy_r >>> cmd.step);
        vy_r <= vy_r - (vx_r >>> cmd.step);
        vz_r <= vz_r + atan_s;
      end else begin
        vx_r <= vx_r - (vy_r >>> cmd.step);
        vy_r <= vy_r + (vx_r >>> cmd.step);
        vz_r <= vz_r - atan_s;
      end
    end
    if (cmd.vec_done) begin
      if (im_r == '0) ph_r <= re_r[26] ? 17'h10000 : 17'h08000;
      else if (vfin < 35'sd0) ph_r <= '0;
      else if (vfin > 35'sd4294967296) ph_r <= 17'h10000;
      else ph_r <= vfin[32:16];
    end
    if (cmd.commit) mem[addr_r] <= res;
    if (cmd.rd_issue) rd_data_r <= mem[rd_idx_r];
    if (cmd.div_init) begin
      rem_r <= num;
      if (mode_r[1]) begin
        pix_r  <= (|num[55:24]) ? 8'hFF : num[23:16];
        dfix_r <= 1'b1;
      end else if (peak_r == '0) begin
        pix_r  <= '0;
        dfix_r <= 1'b1;
      end else if (num >= {peak_r, 8'b0}) begin
        pix_r  <= 8'hFF;
        dfix_r <= 1'b1;
      end else begin
        pix_r  <= '0;
        dfix_r <= 1'b0;
      end
    end
    if (cmd.div_step && !dfix_r && rem_r >= dsub) begin
      rem_r     <= rem_r - dsub;
      pix_r[dk] <= 1'b1;
    end
    if (cmd.emit) begin
      out_pixel_r     <= pix_r;
      out_frame_end_r <= rd_last;
    end
  end

  assign sts.op          = op_r;
  assign sts.frame_ready = frame_ready_r;
  assign sts.mode        = mode_r;
  assign out_pixel       = out_pixel_r;
  assign out_frame_end   = out_frame_end_r;

endmodule
`default_nettype wire

// File: design/offaxis_hologram_render.sv
// Off-axis hologram renderer, top level: ohr_ctrl plus ohr_datapath.
// Depends on ohr_pkg and offaxis_hologram_render_defines.svh.
//
// One item is worked at a time. A sample load runs the rotation CORDIC and
// squarer for intensity, adds a 25-step root for amplitude, and runs the
// rotation plus vectoring CORDIC on one shared sequencer for phase. A pixel
// read does a store read plus an 8-step restoring divider and then waits
// until the result beat is taken. The frame store is MAX_SIDE*MAX_SIDE
// words of 48 bits with one write and one read port. Config writes are
// always ready.
`default_nettype none
`include "offaxis_hologram_render_defines.svh"
module offaxis_hologram_render #(
  parameter int MAX_SIDE     = 512,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic signed [23:0] in_spec_real,
  input  wire logic signed [23:0] in_spec_imag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_pixel,
  output logic                    out_frame_end,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  ohr_pkg::ohr_cmd_t cmd;
  ohr_pkg::ohr_sts_t sts;

  assign cfg_ready = 1'b1;

  ohr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ohr_datapath #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_spec_real  (in_spec_real),
    .in_spec_imag  (in_spec_imag),
    .cfg_wr        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_pixel     (out_pixel),
    .out_frame_end (out_frame_end)
  );

  `OHR_ASSERT_SAME(a_idle_no_result, !in_stall, !out_valid)
  `OHR_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid)
  `OHR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire
